// ===== sv/rsp_pkg.sv =====
// shared types, constants and gf(2^8) helpers for the reed-solomon parity encoder
`timescale 1ns / 1ps
`default_nettype none
package rsp_pkg;

  localparam logic [8:0] GF_POLY        = 9'h11D;
  localparam int         DEG_REG_W      = 6;
  localparam int         DEGREE_RESET   = 10;
  localparam int         MAX_DEGREE_DEF = 32;
  localparam int         BYTE_W         = 8;
  localparam int         PIDX_W         = 5;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;
  } msg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] parity_byte;
    logic [PIDX_W-1:0] parity_index;
    logic              last_parity;
  } par_t;

  // multiply by x modulo the field polynomial
  function automatic logic [7:0] gf_xtime(input logic [7:0] a);
    gf_xtime = {a[6:0], 1'b0} ^ (a[7] ? GF_POLY[7:0] : 8'h00);
  endfunction

  // msb-first shift-and-add multiply
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int bit_i = 7; bit_i >= 0; bit_i--) begin
      acc = gf_xtime(acc);
      if (b[bit_i]) acc = acc ^ a;
    end
    gf_mul = acc;
  endfunction

endpackage
`default_nettype wire

// ===== sv/rsp_gen_build.sv =====
// generator polynomial builder: one root factor folded in per cycle
`timescale 1ns / 1ps
`default_nettype none
module rsp_gen_build #(
  parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  degree_we,
  input  wire logic [rsp_pkg::DEG_REG_W-1:0]         degree_wdata,
  output logic                                       busy,
  output logic [$clog2(MAX_DEGREE+1)-1:0]            eff_deg,
  output logic [MAX_DEGREE-1:0][7:0]                 gen
);
  import rsp_pkg::*;

  localparam int EFF_W     = $clog2(MAX_DEGREE + 1);
  localparam int RESET_EFF = (DEGREE_RESET > MAX_DEGREE) ? MAX_DEGREE :
                             ((DEGREE_RESET < 1) ? 1 : DEGREE_RESET);

  logic [DEG_REG_W:0]           raw;
  logic [EFF_W-1:0]             eff_wr;
  logic [EFF_W-1:0]             cnt;
  logic [7:0]                   root;
  logic [MAX_DEGREE-1:0][7:0]   gen_next;

  assign raw = {1'b0, degree_wdata};

  // zero acts as one, anything above the maximum acts as the maximum
  always_comb begin
    if (raw == '0) begin
      eff_wr = EFF_W'(1);
    end else if (int'(raw) > MAX_DEGREE) begin
      eff_wr = EFF_W'(MAX_DEGREE);
    end else begin
      eff_wr = EFF_W'(raw);
    end
  end

  // gen *= (x - root), all taps from the previous coefficients
  always_comb begin
    for (int j = 0; j < MAX_DEGREE; j++) begin
      gen_next[j] = gf_mul(gen[j], root);
      if (j < MAX_DEGREE - 1) begin
        if (EFF_W'(j + 1) < eff_deg) gen_next[j] = gen_next[j] ^ gen[j+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_deg <= EFF_W'(RESET_EFF);
      busy    <= 1'b1;
      cnt     <= '0;
      root    <= 8'h01;
      for (int j = 0; j < MAX_DEGREE; j++) begin
        gen[j] <= (j == RESET_EFF - 1) ? 8'h01 : 8'h00;
      end
    end else if (degree_we) begin
      eff_deg <= eff_wr;
      busy    <= 1'b1;
      cnt     <= '0;
      root    <= 8'h01;
      for (int j = 0; j < MAX_DEGREE; j++) begin
        gen[j] <= (EFF_W'(j) == eff_wr - EFF_W'(1)) ? 8'h01 : 8'h00;
      end
    end else if (busy) begin
      gen  <= gen_next;
      root <= gf_xtime(root);
      cnt  <= cnt + EFF_W'(1);
      if (cnt == eff_deg - EFF_W'(1)) busy <= 1'b0;
    end
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (cnt < eff_deg))
    else $error("generator build ran past the degree");

endmodule
`default_nettype wire

// ===== sv/rsp_lfsr.sv =====
// input register and remainder division step, one message byte per cycle when msg_stall is low
`timescale 1ns / 1ps
`default_nettype none
module rsp_lfsr #(
  parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  msg_valid,
  output logic                                       msg_stall,
  input  wire rsp_pkg::msg_t                         msg,
  input  wire logic                                  degree_we,
  input  wire logic                                  build_busy,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0]       eff_deg,
  input  wire logic [MAX_DEGREE-1:0][7:0]            gen,
  input  wire logic                                  handoff_ready,
  output logic                                       handoff_valid,
  output logic [MAX_DEGREE-1:0][7:0]                 handoff_rem
);
  import rsp_pkg::*;

  localparam int EFF_W = $clog2(MAX_DEGREE + 1);

  msg_t                       stg;
  logic                       stg_valid;
  logic                       advance;
  logic                       accept;
  logic [7:0]                 factor;
  logic [MAX_DEGREE-1:0][7:0] rem;
  logic [MAX_DEGREE-1:0][7:0] rem_next;

  // a last byte waits until the parity shifter can take the remainder
  assign advance   = stg_valid && (!stg.last_byte || handoff_ready);
  assign msg_stall = build_busy || degree_we || (stg_valid && !advance);
  assign accept    = msg_valid && !msg_stall;

  assign factor = stg.data_byte ^ rem[0];

  always_comb begin
    for (int j = 0; j < MAX_DEGREE; j++) begin
      rem_next[j] = 8'h00;
      if (EFF_W'(j) < eff_deg) begin
        rem_next[j] = gf_mul(gen[j], factor);
        if (j < MAX_DEGREE - 1) begin
          if (EFF_W'(j + 1) < eff_deg) rem_next[j] = rem_next[j] ^ rem[j+1];
        end
      end
    end
  end

  assign handoff_valid = advance && stg.last_byte;
  assign handoff_rem   = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
      rem       <= '0;
    end else if (degree_we) begin
      // new degree drops any partial message
      stg_valid <= 1'b0;
      rem       <= '0;
    end else begin
      if (advance) begin
        rem <= stg.last_byte ? '0 : rem_next;
      end
      if (accept) begin
        stg_valid <= 1'b1;
      end else if (advance) begin
        stg_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) stg <= msg;
  end

  a_handoff_taken: assert property (@(posedge clk) disable iff (rst)
    handoff_valid |-> handoff_ready)
    else $error("remainder handed off while parity shifter busy");

  a_no_accept_building: assert property (@(posedge clk) disable iff (rst)
    build_busy |=> !($past(accept)))
    else $error("message byte taken while generator is being built");

endmodule
`default_nettype wire

// ===== sv/rsp_par_out.sv =====
// parity shift register, one parity byte per output transaction
`timescale 1ns / 1ps
`default_nettype none
module rsp_par_out #(
  parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0]       eff_deg,
  input  wire logic                                  handoff_valid,
  input  wire logic [MAX_DEGREE-1:0][7:0]            handoff_rem,
  output logic                                       handoff_ready,
  output logic                                       par_valid,
  input  wire logic                                  par_stall,
  output rsp_pkg::par_t                              par
);
  import rsp_pkg::*;

  localparam int EFF_W = $clog2(MAX_DEGREE + 1);
  localparam int IDX_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  logic                       busy;
  logic [IDX_W-1:0]           idx;
  logic [MAX_DEGREE-1:0][7:0] sh;
  logic                       at_last;
  logic                       pop;
  logic [63:0]                idx_wide;

  assign at_last       = (EFF_W'(idx) == eff_deg - EFF_W'(1));
  assign pop           = busy && !par_stall;
  assign handoff_ready = !busy || (pop && at_last);

  assign idx_wide         = 64'(idx);
  assign par_valid        = busy;
  assign par.parity_byte  = sh[0];
  assign par.parity_index = idx_wide[PIDX_W-1:0];
  assign par.last_parity  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (handoff_valid) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (pop) begin
      idx <= idx + IDX_W'(1);
      if (at_last) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (handoff_valid) begin
      sh <= handoff_rem;
    end else if (pop) begin
      for (int j = 0; j < MAX_DEGREE - 1; j++) begin
        sh[j] <= sh[j+1];
      end
      sh[MAX_DEGREE-1] <= 8'h00;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (EFF_W'(idx) < eff_deg))
    else $error("parity index beyond the degree");

  a_load_starts_run: assert property (@(posedge clk) disable iff (rst)
    handoff_valid |=> (busy && idx == '0))
    else $error("parity run did not start at index zero");

endmodule
`default_nettype wire

// ===== sv/reed_solomon_parity_encoder.sv =====
// reed-solomon parity encoder over gf(2^8), field polynomial 0x11d
//
//   port group                 dir   meaning
//   msg_valid/msg_stall/msg    in    message bytes, last_byte marks the end
//   par_valid/par_stall/par    out   parity bytes, highest power first
//   degree_we/degree_wdata     in    degree register write
//
// one message byte per cycle unless stalled; bytes wait in the input register
// the generator builder runs after reset and after each degree write, folding in
// one root per cycle; msg_stall is high meanwhile
// a last byte hands its remainder to the parity shifter, which sends eff_degree
// bytes, one per cycle when not stalled, while the next message streams in
// a further last byte waits until the shifter has sent its final byte
// rst is synchronous and active high
`timescale 1ns / 1ps
`default_nettype none
module reed_solomon_parity_encoder #(
  parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          msg_valid,
  output logic                               msg_stall,
  input  wire rsp_pkg::msg_t                 msg,
  output logic                               par_valid,
  input  wire logic                          par_stall,
  output rsp_pkg::par_t                      par,
  input  wire logic                          degree_we,
  input  wire logic [rsp_pkg::DEG_REG_W-1:0] degree_wdata
);
  import rsp_pkg::*;

  localparam int EFF_W = $clog2(MAX_DEGREE + 1);

  logic                       build_busy;
  logic [EFF_W-1:0]           eff_deg;
  logic [MAX_DEGREE-1:0][7:0] gen;
  logic                       handoff_valid;
  logic                       handoff_ready;
  logic [MAX_DEGREE-1:0][7:0] handoff_rem;

  rsp_gen_build #(.MAX_DEGREE(MAX_DEGREE)) u_gen (
    .clk          (clk),
    .rst          (rst),
    .degree_we    (degree_we),
    .degree_wdata (degree_wdata),
    .busy         (build_busy),
    .eff_deg      (eff_deg),
    .gen          (gen)
  );

  rsp_lfsr #(.MAX_DEGREE(MAX_DEGREE)) u_lfsr (
    .clk           (clk),
    .rst           (rst),
    .msg_valid     (msg_valid),
    .msg_stall     (msg_stall),
    .msg           (msg),
    .degree_we     (degree_we),
    .build_busy    (build_busy),
    .eff_deg       (eff_deg),
    .gen           (gen),
    .handoff_ready (handoff_ready),
    .handoff_valid (handoff_valid),
    .handoff_rem   (handoff_rem)
  );

  rsp_par_out #(.MAX_DEGREE(MAX_DEGREE)) u_out (
    .clk           (clk),
    .rst           (rst),
    .eff_deg       (eff_deg),
    .handoff_valid (handoff_valid),
    .handoff_rem   (handoff_rem),
    .handoff_ready (handoff_ready),
    .par_valid     (par_valid),
    .par_stall     (par_stall),
    .par           (par)
  );

endmodule
`default_nettype wire
